[design/siv_pkg.sv]
// shared types and constants of the string input validator
package siv_pkg;

	localparam int COUNT_BITS = 17;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_STRICT     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PATH_ON    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SQL_ON     = 3'd4;

	localparam logic [15:0] MAX_LENGTH_RST = 16'd1024;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_TOO_LONG = 3'd1;
	localparam logic [2:0] ERR_PATH     = 3'd2;
	localparam logic [2:0] ERR_CHAR     = 3'd3;
	localparam logic [2:0] ERR_SQL      = 3'd4;

	// request bits latched on the first item of a string
	localparam int REQ_PATH = 0;
	localparam int REQ_TEXT = 1;
	localparam int REQ_SQL  = 2;

	typedef struct packed {
		logic       first;
		logic       last;
		logic       path_hit;
		logic       ctrl_hit;
		logic       sql_hit;
		logic [2:0] reqs;
	} flags_t;

	typedef struct packed {
		logic        enable;
		logic        strict_mode;
		logic [15:0] max_length;
		logic        path_checks_on;
		logic        sql_checks_on;
	} cfg_t;

endpackage

[design/siv_if.sv]
// request and verdict channel interfaces
interface siv_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;
	logic       want_path;
	logic       want_text;
	logic       want_sql;

	modport source (
		output valid, data_byte, byte_present, last, want_path, want_text, want_sql,
		input  ready
	);
	modport sink (
		input  valid, data_byte, byte_present, last, want_path, want_text, want_sql,
		output ready
	);
endinterface

interface siv_verdict_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [2:0] error_code;

	modport source (
		output valid, valid_res, error_code,
		input  ready
	);
	modport sink (
		input  valid, valid_res, error_code,
		output ready
	);
endinterface

[design/siv_queue.sv]
// small fifo between the classifying front and the verdict back
module siv_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              not_empty
);

	logic [DATA_W-1:0]           mem_q [siv_pkg::QUEUE_DEPTH];
	logic [siv_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [siv_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [siv_pkg::Q_CNT_W-1:0] cnt_q;

	localparam logic [siv_pkg::Q_PTR_W-1:0] PTR_LAST =
		siv_pkg::Q_PTR_W'(siv_pkg::QUEUE_DEPTH - 1);

	assign full      = (cnt_q == siv_pkg::Q_CNT_W'(siv_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/siv_front.sv]
// front end: takes bytes, tracks the window and length, classifies each byte
module siv_front #(
	parameter int COUNT_BITS = siv_pkg::COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	siv_item_if.sink              item,
	input  logic                  q_full,
	output logic                  push,
	output siv_pkg::flags_t       flags,
	output logic [COUNT_BITS-1:0] count
);

	logic                  in_string_q;
	logic [39:0]           recent_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]            second_q;

	logic                  start;
	logic [39:0]           rec;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [7:0]            sec;
	logic [7:0]            c;
	logic [47:0]           win;
	logic                  slash;
	logic                  special;
	logic                  path_hit;
	logic                  ctrl_hit;
	logic                  sql_hit;

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	// a new string starts from a clean window
	assign start = !in_string_q;
	assign rec   = start ? '0 : recent_q;
	assign cnt   = start ? '0 : count_q;
	assign sec   = start ? '0 : second_q;
	assign c     = item.data_byte;
	assign win   = {rec, c};

	assign cnt_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);

	assign slash   = (c == "/") || (c == "\\");
	assign special = (c == "<") || (c == ">") || (c == "|") || (c == "?") ||
		(c == "*") || (c == "\"");

	assign path_hit = item.byte_present && ((win[15:0] == "..") || special ||
		((cnt == '0) && slash) ||
		((cnt == COUNT_BITS'(2)) && (sec == ":") && slash));

	assign ctrl_hit = item.byte_present && (c >= 8'd9) && (c <= 8'd13);

	assign sql_hit = item.byte_present && ((win[39:0] == "UNION") ||
		(win[47:0] == "SELECT") || (win[47:0] == "INSERT") ||
		(win[47:0] == "UPDATE") || (win[47:0] == "DELETE") ||
		(win[31:0] == "DROP") || (win[15:0] == "--") ||
		(win[15:0] == "/*") || (win[15:0] == "*/"));

	always_comb begin
		flags          = '0;
		flags.first    = start;
		flags.last     = item.last;
		flags.path_hit = path_hit;
		flags.ctrl_hit = ctrl_hit;
		flags.sql_hit  = sql_hit;
		flags.reqs[siv_pkg::REQ_PATH] = item.want_path;
		flags.reqs[siv_pkg::REQ_TEXT] = item.want_text;
		flags.reqs[siv_pkg::REQ_SQL]  = item.want_sql;
	end

	assign count = item.byte_present ? cnt_inc : cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
		end else if (push) begin
			in_string_q <= !item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (item.byte_present) begin
				recent_q <= win[39:0];
				count_q  <= cnt_inc;
				second_q <= (cnt == COUNT_BITS'(1)) ? c : sec;
			end else begin
				recent_q <= rec;
				count_q  <= cnt;
				second_q <= sec;
			end
		end
	end

endmodule

[design/siv_back.sv]
// back end: folds byte flags per string and registers the verdict
module siv_back #(
	parameter int COUNT_BITS = siv_pkg::COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  siv_pkg::flags_t       head,
	input  logic [COUNT_BITS-1:0] head_count,
	input  siv_pkg::cfg_t         cfg,
	output logic                  q_pop,
	siv_verdict_if.source         verdict
);

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic       acc_path_q;
	logic       acc_ctrl_q;
	logic       acc_sql_q;
	logic [2:0] req_q;
	logic       res_valid_q;
	logic       valid_res_q;
	logic [2:0] code_q;

	logic       out_free;
	logic [2:0] req;
	logic       path_seen;
	logic       ctrl_seen;
	logic       sql_seen;
	logic       too_long;
	logic       empty_str;
	logic [2:0] code;

	assign out_free = !res_valid_q || verdict.ready;
	assign q_pop    = q_valid && (!head.last || out_free);

	assign req       = head.first ? head.reqs : req_q;
	assign path_seen = (!head.first && acc_path_q) || head.path_hit;
	assign ctrl_seen = (!head.first && acc_ctrl_q) || head.ctrl_hit;
	assign sql_seen  = (!head.first && acc_sql_q) || head.sql_hit;
	assign too_long  = CMP_W'(head_count) > CMP_W'(cfg.max_length);
	assign empty_str = (head_count == '0);

	always_comb begin
		code = siv_pkg::ERR_NONE;
		priority if (!cfg.enable) begin
			code = siv_pkg::ERR_NONE;
		end else if (too_long) begin
			code = siv_pkg::ERR_TOO_LONG;
		end else if (cfg.path_checks_on && req[siv_pkg::REQ_PATH] &&
				(path_seen || empty_str)) begin
			code = siv_pkg::ERR_PATH;
		end else if (req[siv_pkg::REQ_TEXT] && cfg.strict_mode && ctrl_seen) begin
			code = siv_pkg::ERR_CHAR;
		end else if (cfg.sql_checks_on && req[siv_pkg::REQ_SQL] && cfg.strict_mode &&
				sql_seen) begin
			code = siv_pkg::ERR_SQL;
		end else begin
			code = siv_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_path_q <= path_seen;
			acc_ctrl_q <= ctrl_seen;
			acc_sql_q  <= sql_seen;
			req_q      <= req;
		end
		if (q_pop && head.last) begin
			valid_res_q <= (code == siv_pkg::ERR_NONE);
			code_q      <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && head.last) begin
			res_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign verdict.valid      = res_valid_q;
	assign verdict.valid_res  = valid_res_q;
	assign verdict.error_code = code_q;

endmodule

[design/string_input_validator.sv]
// string input validator top level: config registers, front, queue and back
//
// item channel: one character per request with byte_present, last and the
// want_* check requests, which count only on the first request of a string.
// an item with byte_present low adds no character but can open or close a
// string, so a lone absent item with last high is an empty string.
// verdict channel: one request per string, sent for the item with last high,
// carrying valid_res and error_code (none, too long, path, character, sql).
// throughput is one item per cycle while the queue is not full; the front
// classifies a byte in the cycle it is taken and writes a four-entry queue,
// the back folds one queue entry per cycle into the string flags (holding a
// last entry while an earlier verdict is unaccepted) and loads the verdict
// register; a last item reaches it behind any entries queued ahead of it.
// when the verdict receiver stalls, non-last entries keep draining; the queue
// fills behind a waiting last entry and item ready falls once it holds four.
// the user must write config registers via the apb port with the block idle;
// the block does not enforce it. they are read when a string's last entry pops.
// reset clears the string state, empties the queue, drops verdict valid and
// loads the register defaults: enabled, not strict, limit 1024, checks on.
module string_input_validator #(
	parameter int COUNT_BITS = siv_pkg::COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	siv_item_if.sink                       item,
	siv_verdict_if.source                  verdict,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [siv_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [siv_pkg::APB_DATA_W-1:0] pwdata,
	output logic [siv_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int Q_W = $bits(siv_pkg::flags_t) + COUNT_BITS;

	siv_pkg::cfg_t                 cfg_q;
	logic [siv_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	siv_pkg::flags_t       front_flags;
	logic [COUNT_BITS-1:0] front_count;
	siv_pkg::flags_t       head_flags;
	logic [COUNT_BITS-1:0] head_count;
	logic [Q_W-1:0]        q_din;
	logic [Q_W-1:0]        q_dout;

	assign pready  = 1'b1;
	assign reg_idx = paddr[siv_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable         <= 1'b1;
			cfg_q.strict_mode    <= 1'b0;
			cfg_q.max_length     <= siv_pkg::MAX_LENGTH_RST;
			cfg_q.path_checks_on <= 1'b1;
			cfg_q.sql_checks_on  <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				siv_pkg::REG_ENABLE:     cfg_q.enable         <= pwdata[0];
				siv_pkg::REG_STRICT:     cfg_q.strict_mode    <= pwdata[0];
				siv_pkg::REG_MAX_LENGTH: cfg_q.max_length     <= pwdata[15:0];
				siv_pkg::REG_PATH_ON:    cfg_q.path_checks_on <= pwdata[0];
				siv_pkg::REG_SQL_ON:     cfg_q.sql_checks_on  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			siv_pkg::REG_ENABLE:     prdata[0]    = cfg_q.enable;
			siv_pkg::REG_STRICT:     prdata[0]    = cfg_q.strict_mode;
			siv_pkg::REG_MAX_LENGTH: prdata[15:0] = cfg_q.max_length;
			siv_pkg::REG_PATH_ON:    prdata[0]    = cfg_q.path_checks_on;
			siv_pkg::REG_SQL_ON:     prdata[0]    = cfg_q.sql_checks_on;
			default:                 prdata       = '0;
		endcase
	end

	siv_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (q_push),
		.flags  (front_flags),
		.count  (front_count)
	);

	assign q_din = {front_flags, front_count};

	siv_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_valid)
	);

	assign head_flags = q_dout[Q_W-1:COUNT_BITS];
	assign head_count = q_dout[COUNT_BITS-1:0];

	siv_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head_flags),
		.head_count (head_count),
		.cfg        (cfg_q),
		.q_pop      (q_pop),
		.verdict    (verdict)
	);

endmodule

[design/siv_checker.sv]
// port-level checks on the verdict channel, bound to the top level
module siv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       valid_res,
	input logic [2:0] error_code
);

	// a passing string carries no error code
	a_pass_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |-> error_code == siv_pkg::ERR_NONE)
		else $error("passing verdict with nonzero error code");

	// a failing string names one of the four checks
	a_fail_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |->
			error_code == siv_pkg::ERR_TOO_LONG || error_code == siv_pkg::ERR_PATH ||
			error_code == siv_pkg::ERR_CHAR || error_code == siv_pkg::ERR_SQL)
		else $error("failing verdict without a known error code");

	// a stalled verdict stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(valid_res) && $stable(error_code))
		else $error("verdict changed while stalled");

endmodule

bind string_input_validator siv_checker u_siv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (verdict.valid),
	.res_ready  (verdict.ready),
	.valid_res  (verdict.valid_res),
	.error_code (verdict.error_code)
);
